// ===== src/tiled_palette_texture_decoder_defines.svh =====
// Assertion macros for the checker file of the tiled palette texture decoder
`ifndef TILED_PALETTE_TEXTURE_DECODER_DEFINES_SVH
`define TILED_PALETTE_TEXTURE_DECODER_DEFINES_SVH

// Clocked assertion, switched off while reset is held
`define TPTD_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define TPTD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tptd_pkg.sv =====
// Package: types, constants and colour decode for the tiled palette texture decoder
package tptd_pkg;

    localparam int DIM_W         = 10;
    localparam int MAX_DIM       = 512;
    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int FILL_W        = TABLE_AW + 1;
    localparam int PIX_W         = 18;
    localparam int RGBA_W        = 32;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);
    localparam int REG_IDX_W     = 2;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = ((PIX_W + RGBA_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FMT_ALPHA8,
        FMT_RGB655,
        FMT_ABGR4444,
        FMT_RGBA8888
    } color_fmt_t;

    typedef enum logic {
        LAYOUT_DIRECT,
        LAYOUT_PALETTE
    } layout_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COLOR_FORMAT,
        REG_TILE_LAYOUT,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } reg_idx_t;

    typedef struct packed {
        color_fmt_t         color_format;
        layout_t            tile_layout;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } cfg_t;

    // One request from the front to the back: a palette write or a pixel
    typedef struct packed {
        logic                is_write;
        logic                is_lookup;
        logic [TABLE_AW-1:0] addr;
        logic [RGBA_W-1:0]   rgba;
        logic [PIX_W-1:0]    pixel_index;
        logic                last;
    } work_t;

    // Red in the low byte, then green, blue, alpha
    function automatic logic [RGBA_W-1:0] decode_color(color_fmt_t fmt,
                                                        logic [23:0] gather,
                                                        logic [7:0] last_byte);
        logic [15:0] v;
        logic [RGBA_W-1:0] res;
        v = {last_byte, gather[7:0]};
        case (fmt)
            FMT_ALPHA8:   res = {last_byte, 8'hFF, 8'hFF, 8'hFF};
            // x8 scaling; red keeps six bits, so its top bit falls off
            FMT_RGB655:   res = {8'hFF, v[15:11], 3'b000, v[10:6], 3'b000,
                                 v[4:0], 3'b000};
            // x17 replicates the nibble
            FMT_ABGR4444: res = {v[15:12], v[15:12], v[11:8], v[11:8],
                                 v[7:4], v[7:4], v[3:0], v[3:0]};
            FMT_RGBA8888: res = {last_byte, gather[23:16], gather[15:8], gather[7:0]};
            default:      res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== src/tptd_cfg.sv =====
// Configuration register bank
module tptd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [tptd_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tptd_pkg::DIM_W-1:0]     cfg_data,
    output tptd_pkg::cfg_t                 cfg
);
    import tptd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_COLOR_FORMAT: cfg_next.color_format = color_fmt_t'(cfg_data[1:0]);
                REG_TILE_LAYOUT:  cfg_next.tile_layout  = layout_t'(cfg_data[0]);
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data;
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_format <= FMT_RGBA8888;
            cfg_reg.tile_layout  <= LAYOUT_PALETTE;
            cfg_reg.image_width  <= DIM_W'(MAX_DIM);
            cfg_reg.image_height <= DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/tptd_fifo.sv =====
// Short request queue between front and back
module tptd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tptd_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output tptd_pkg::work_t head,
    output logic            empty
);
    import tptd_pkg::*;

    work_t           entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/tptd_front.sv =====
// Front: byte assembly, palette fill count, tile walk and raster index
module tptd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  tptd_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      data_byte,
    input  logic            frame_start,
    input  logic            q_full,
    output logic            push,
    output tptd_pkg::work_t push_data
);
    import tptd_pkg::*;

    logic [23:0]       gather_reg, gather_next, gather_e;
    logic [1:0]        phase_reg, phase_next, phase_e;
    logic [FILL_W-1:0] fill_reg, fill_next, fill_e;
    logic [3:0]        col_reg, col_next, col_e;
    logic [2:0]        row_reg, row_next, row_e;
    logic [5:0]        tcol_reg, tcol_next, tcol_e;
    logic [5:0]        trow_reg, trow_next, trow_e;
    logic              done_reg, done_next, done_e;

    logic              accept;
    logic [DIM_W-1:0]  w_c, h_c;
    logic [4:0]        tile_w;
    logic [6:0]        tiles_x, tiles_y;
    logic              can_emit;
    logic [2:0]        need;
    logic [RGBA_W-1:0] decoded;

    logic [4:0]        col_inc;
    logic [3:0]        row_inc;
    logic [6:0]        tcol_inc, trow_inc;
    logic [3:0]        adv_col;
    logic [2:0]        adv_row;
    logic [5:0]        adv_tcol, adv_trow;
    logic              adv_last;

    logic [8:0]        row_pos;
    logic [9:0]        col_pos;
    logic [18:0]       prod;
    logic [18:0]       pix_sum;

    logic              emit_req;
    logic              emit_lookup;
    logic [RGBA_W-1:0] emit_rgba;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Start of frame clears the running state before this byte is used
    assign gather_e = frame_start ? '0 : gather_reg;
    assign phase_e  = frame_start ? '0 : phase_reg;
    assign fill_e   = frame_start ? '0 : fill_reg;
    assign col_e    = frame_start ? '0 : col_reg;
    assign row_e    = frame_start ? '0 : row_reg;
    assign tcol_e   = frame_start ? '0 : tcol_reg;
    assign trow_e   = frame_start ? '0 : trow_reg;
    assign done_e   = frame_start ? 1'b0 : done_reg;

    assign w_c = (cfg.image_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_width;
    assign h_c = (cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.image_height;

    always_comb
    begin
        if (cfg.tile_layout == LAYOUT_PALETTE)
        begin
            tile_w  = 5'd16;
            tiles_x = {1'b0, w_c[9:4]};
            col_pos = {tcol_e, col_e};
        end
        else
        begin
            tile_w  = 5'd8;
            tiles_x = w_c[9:3];
            col_pos = {1'b0, tcol_e, 3'b000} + {6'b0, col_e};
        end
        tiles_y  = h_c[9:3];
        can_emit = !done_e && (tiles_x != '0) && (tiles_y != '0);
    end

    always_comb
    begin
        case (cfg.color_format)
            FMT_ALPHA8:   need = 3'd1;
            FMT_RGBA8888: need = 3'd4;
            default:      need = 3'd2;
        endcase
    end

    assign decoded = decode_color(cfg.color_format, gather_e, data_byte);

    assign row_pos = {trow_e, row_e};
    assign prod    = 19'(row_pos) * 19'(w_c);
    assign pix_sum = prod + {9'b0, col_pos};

    // Tile walk: columns, rows of a tile, tiles across, tiles down
    always_comb
    begin
        col_inc  = {1'b0, col_e} + 5'd1;
        row_inc  = {1'b0, row_e} + 4'd1;
        tcol_inc = {1'b0, tcol_e} + 7'd1;
        trow_inc = {1'b0, trow_e} + 7'd1;
        adv_col  = col_inc[3:0];
        adv_row  = row_e;
        adv_tcol = tcol_e;
        adv_trow = trow_e;
        adv_last = 1'b0;
        if (col_inc >= tile_w)
        begin
            adv_col = '0;
            if (row_inc >= 4'd8)
            begin
                adv_row = '0;
                if (tcol_inc >= tiles_x)
                begin
                    adv_tcol = '0;
                    if (trow_inc >= tiles_y)
                    begin
                        adv_trow = '0;
                        adv_last = 1'b1;
                    end
                    else
                    begin
                        adv_trow = trow_inc[5:0];
                    end
                end
                else
                begin
                    adv_tcol = tcol_inc[5:0];
                end
            end
            else
            begin
                adv_row = row_inc[2:0];
            end
        end
    end

    always_comb
    begin
        gather_next = gather_reg;
        phase_next  = phase_reg;
        fill_next   = fill_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        tcol_next   = tcol_reg;
        trow_next   = trow_reg;
        done_next   = done_reg;
        push        = 1'b0;
        push_data   = '0;
        emit_req    = 1'b0;
        emit_lookup = 1'b0;
        emit_rgba   = '0;
        if (accept)
        begin
            gather_next = gather_e;
            phase_next  = phase_e;
            fill_next   = fill_e;
            col_next    = col_e;
            row_next    = row_e;
            tcol_next   = tcol_e;
            trow_next   = trow_e;
            done_next   = done_e;
            if (cfg.tile_layout == LAYOUT_PALETTE && fill_e[FILL_W-1])
            begin
                emit_req    = 1'b1;
                emit_lookup = 1'b1;
            end
            else if (!(done_e && cfg.tile_layout == LAYOUT_DIRECT))
            begin
                if (({1'b0, phase_e} + 3'd1) < need)
                begin
                    case (phase_e)
                        2'd0:    gather_next = {gather_e[23:8], data_byte};
                        2'd1:    gather_next = {gather_e[23:16], data_byte, gather_e[7:0]};
                        2'd2:    gather_next = {data_byte, gather_e[15:0]};
                        default: gather_next = gather_e;
                    endcase
                    phase_next = phase_e + 2'd1;
                end
                else
                begin
                    gather_next = '0;
                    phase_next  = '0;
                    if (cfg.tile_layout == LAYOUT_PALETTE)
                    begin
                        push               = 1'b1;
                        push_data.is_write = 1'b1;
                        push_data.addr     = fill_e[TABLE_AW-1:0];
                        push_data.rgba     = decoded;
                        fill_next          = fill_e + 1'b1;
                    end
                    else
                    begin
                        emit_req  = 1'b1;
                        emit_rgba = decoded;
                    end
                end
            end
            if (emit_req && can_emit)
            begin
                push                  = 1'b1;
                push_data.is_lookup   = emit_lookup;
                push_data.addr        = data_byte;
                push_data.rgba        = emit_rgba;
                push_data.pixel_index = pix_sum[PIX_W-1:0];
                push_data.last        = adv_last;
                col_next              = adv_col;
                row_next              = adv_row;
                tcol_next             = adv_tcol;
                trow_next             = adv_trow;
                done_next             = done_e || adv_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= '0;
            phase_reg  <= '0;
            fill_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            tcol_reg   <= '0;
            trow_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            gather_reg <= gather_next;
            phase_reg  <= phase_next;
            fill_reg   <= fill_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            tcol_reg   <= tcol_next;
            trow_reg   <= trow_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== src/tptd_back.sv =====
// Back: palette memory, lookup stage and output register
module tptd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  tptd_pkg::work_t               head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tptd_pkg::PIX_W-1:0]    pixel_index,
    output logic [tptd_pkg::RGBA_W-1:0]   rgba,
    output logic                          last_pixel
);
    import tptd_pkg::*;

    logic [RGBA_W-1:0] table_mem [TABLE_ENTRIES];
    logic [RGBA_W-1:0] rd_data_reg;

    logic              s1_valid_reg, s1_valid_next;
    work_t             s1_reg;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_index_reg;
    logic [RGBA_W-1:0] out_rgba_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              s1_adv;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = !s1_valid_reg || out_free;
    assign pop      = !q_empty && s1_adv;

    always_comb
    begin
        s1_valid_next  = s1_adv ? (pop && !head.is_write) : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Palette: one write or one read per popped request
    always_ff @(posedge clk)
    begin
        if (pop && head.is_write)
        begin
            table_mem[head.addr] <= head.rgba;
        end
        if (pop && !head.is_write)
        begin
            rd_data_reg <= table_mem[head.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= head;
        end
        if (out_free && s1_valid_reg)
        begin
            out_index_reg <= s1_reg.pixel_index;
            out_rgba_reg  <= s1_reg.is_lookup ? rd_data_reg : s1_reg.rgba;
            out_last_reg  <= s1_reg.last;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign pixel_index = out_index_reg;
    assign rgba        = out_rgba_reg;
    assign last_pixel  = out_last_reg;

endmodule

// ===== src/tiled_palette_texture_decoder.sv =====
// Top level: tiled palette texture decoder
// Takes one body byte per cycle while the request queue has room; a pixel passes through
// the request queue, the lookup stage and the output register on its way out.
// The front walks bytes and tiles as each byte is taken; a four-entry request queue lets it
// run on while the back (palette read and output register) is held by the sink.
// rst_n clears counters, queue and config (rgba8888, palette, 512x512);
// the palette memory is not cleared and is filled by each frame before use.
module tiled_palette_texture_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tptd_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                               s_tuser,   // frame_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [17:0] pixel_index, [25:18] red, [33:26] green, [41:34] blue, [49:42] alpha, rest 0
    output logic [tptd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,   // last_pixel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tptd_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [tptd_pkg::DIM_W-1:0]         cfg_data
);
    import tptd_pkg::*;

    cfg_t              cfg;
    logic              q_push, q_pop, q_full, q_empty;
    work_t             q_in, q_head;
    logic [PIX_W-1:0]  pixel_index;
    logic [RGBA_W-1:0] rgba;

    assign cfg_ready = 1'b1;

    tptd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tptd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .data_byte   (s_tdata[7:0]),
        .frame_start (s_tuser),
        .q_full      (q_full),
        .push        (q_push),
        .push_data   (q_in)
    );

    tptd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    tptd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (q_head),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .pixel_index (pixel_index),
        .rgba        (rgba),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = {(M_TDATA_W - PIX_W - RGBA_W)'(0), rgba, pixel_index};

endmodule

// ===== src/tptd_checker.sv =====
// Port-level checker for the tiled palette texture decoder, with its bind
`include "tiled_palette_texture_decoder_defines.svh"

module tptd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tptd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import tptd_pkg::*;

    // a stalled pixel stays put
    `TPTD_ASSERT_RST(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output request changed while stalled")

    // the queue only fills when the sink held the output on the previous cycle
    `TPTD_ASSERT_RST(a_in_backpressure, clk, rst_n, !s_tready |-> $past(m_tvalid && !m_tready), "input stalled without output back-pressure")

    // input side never blocks on its own while the output stays empty
    `TPTD_ASSERT_RST(a_in_ready_flow, clk, rst_n, !$past(m_tvalid) && !m_tvalid |-> s_tready, "input stalled with an empty output")

    // padding above alpha is zero
    `TPTD_ASSERT_ALWAYS(a_pad_zero, clk, !m_tvalid || (m_tdata[M_TDATA_W-1:PIX_W+RGBA_W] == '0), "padding bits set")

endmodule

bind tiled_palette_texture_decoder tptd_checker u_tptd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/tptd_pixel_checker.sv =====
// Pixel checker: follows the byte, pixel and register requests and compares every pixel
module tptd_pixel_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [tptd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [tptd_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [tptd_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [tptd_pkg::DIM_W-1:0]        cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    import tptd_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             last_pixel;
    } pixel_t;

    pixel_t       expected_pixels[$];
    pixel_t       want;
    logic [31:0]  palette [TABLE_ENTRIES];
    color_fmt_t   fmt;
    layout_t      layout;
    int unsigned  width_reg;
    int unsigned  height_reg;
    int unsigned  gather;
    int unsigned  phase;
    int unsigned  fill_count;
    int unsigned  col_in_tile;
    int unsigned  row_in_tile;
    int unsigned  tile_col;
    int unsigned  tile_row;
    bit           done;

    function automatic logic [31:0] rgba(int unsigned r, int unsigned g, int unsigned b,
                                         int unsigned a);
        return {a[7:0], b[7:0], g[7:0], r[7:0]};
    endfunction

    function automatic logic [31:0] texel(color_fmt_t f, int unsigned g, int unsigned b);
        int unsigned v;
        v = (g & 'hFF) | (b << 8);
        case (f)
            FMT_ALPHA8:   return rgba(255, 255, 255, b);
            // red keeps six bits, so x8 wraps past the byte
            FMT_RGB655:   return rgba(8 * (v & 'h3F), 8 * ((v >> 6) & 'h1F),
                                      8 * ((v >> 11) & 'h1F), 255);
            FMT_ABGR4444: return rgba(17 * (v & 'hF), 17 * ((v >> 4) & 'hF),
                                      17 * ((v >> 8) & 'hF), 17 * ((v >> 12) & 'hF));
            default:      return rgba(g, g >> 8, g >> 16, b);
        endcase
    endfunction

    task automatic rewind_frame;
        gather      = 0;
        phase       = 0;
        fill_count  = 0;
        col_in_tile = 0;
        row_in_tile = 0;
        tile_col    = 0;
        tile_row    = 0;
        done        = 1'b0;
    endtask

    task automatic place_pixel(input logic [31:0] colour);
        int unsigned w;
        int unsigned h;
        int unsigned tw;
        int unsigned tiles_x;
        int unsigned tiles_y;
        int unsigned row;
        int unsigned col;
        int unsigned idx;
        pixel_t      px;
        w  = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
        h  = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
        tw = (layout == LAYOUT_PALETTE) ? 16 : 8;
        tiles_x = w / tw;
        tiles_y = h / 8;
        if (done || tiles_x == 0 || tiles_y == 0)
            return;
        row = tile_row * 8 + row_in_tile;
        col = tile_col * tw + col_in_tile;
        px.last_pixel = 1'b0;
        // >= tests so that a smaller geometry mid image folds the counters back
        col_in_tile++;
        if (col_in_tile >= tw)
        begin
            col_in_tile = 0;
            row_in_tile++;
            if (row_in_tile >= 8)
            begin
                row_in_tile = 0;
                tile_col++;
                if (tile_col >= tiles_x)
                begin
                    tile_col = 0;
                    tile_row++;
                    if (tile_row >= tiles_y)
                    begin
                        tile_row = 0;
                        done = 1'b1;
                        px.last_pixel = 1'b1;
                    end
                end
            end
        end
        idx = row * w + col;
        px.pixel_index = idx[PIX_W-1:0];
        px.red   = colour[7:0];
        px.green = colour[15:8];
        px.blue  = colour[23:16];
        px.alpha = colour[31:24];
        expected_pixels = {expected_pixels, px};
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic frame_start);
        int unsigned bv;
        int unsigned need;
        logic [31:0] colour;
        bv = {24'b0, b};
        if (frame_start)
            rewind_frame();
        if (layout == LAYOUT_PALETTE && fill_count >= TABLE_ENTRIES)
        begin
            place_pixel(palette[b]);
            return;
        end
        if (done && layout == LAYOUT_DIRECT)
            return;
        need = (fmt == FMT_ALPHA8) ? 1 : ((fmt == FMT_RGBA8888) ? 4 : 2);
        if (phase + 1 < need)
        begin
            gather = (gather | (bv << (8 * phase))) & 'hFFFFFF;
            phase  = (phase + 1) & 3;
            return;
        end
        colour = texel(fmt, gather, bv);
        gather = 0;
        phase  = 0;
        if (layout == LAYOUT_PALETTE)
        begin
            palette[fill_count % TABLE_ENTRIES] = colour;
            fill_count++;
            return;
        end
        place_pixel(colour);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rewind_frame();
            fmt         = FMT_RGBA8888;
            layout      = LAYOUT_PALETTE;
            width_reg   = MAX_DIM;
            height_reg  = MAX_DIM;
            mismatches  = 0;
            outstanding = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COLOR_FORMAT: fmt        = color_fmt_t'(cfg_data[1:0]);
                    REG_TILE_LAYOUT:  layout     = layout_t'(cfg_data[0]);
                    REG_IMAGE_WIDTH:  width_reg  = 32'(cfg_data);
                    REG_IMAGE_HEIGHT: height_reg = 32'(cfg_data);
                    default: ;
                endcase
            end
            // byte side first: a pixel never leaves in the cycle its byte is taken
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata[7:0], s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel request with none expected: pixel_index %0d",
                           m_tdata[PIX_W-1:0]);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_index", 32'(want.pixel_index),
                                32'(m_tdata[PIX_W-1:0]));
                    check_field("red",   32'(want.red),   32'(m_tdata[PIX_W +: 8]));
                    check_field("green", 32'(want.green), 32'(m_tdata[PIX_W + 8 +: 8]));
                    check_field("blue",  32'(want.blue),  32'(m_tdata[PIX_W + 16 +: 8]));
                    check_field("alpha", 32'(want.alpha), 32'(m_tdata[PIX_W + 24 +: 8]));
                    check_field("last_pixel", 32'(want.last_pixel), 32'(m_tlast));
                end
            end
            outstanding = expected_pixels.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, byte and register stimulus, sink and verdict for the decoder
module tb_top;
    import tptd_pkg::*;

    localparam int RANDOM_BYTES   = 850;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SINK_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [REG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;

    int mismatches;
    int outstanding;
    int send_idle    = 0;
    int sink_stall   = 0;
    int quiet_cycles = 0;
    int bytes_sent   = 0;
    bit hold_sink    = 1'b0;

    tiled_palette_texture_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tptd_pixel_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sink: random stalls, or one long hold-off when asked
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(posedge clk);
                hold_sink = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= sink_stall);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request taken for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Valid stays high into the next byte unless an idle gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic frame_start);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= frame_start;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        // a byte that makes no pixel may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic change_reg(input reg_idx_t idx, input logic [DIM_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup_image(input color_fmt_t f, input layout_t l, input int w,
                               input int h);
        logic [DIM_W-1:0] junk;
        junk = DIM_W'($urandom);
        if ($urandom_range(1))
            junk = '0;
        // upper bits of the narrow registers must be dropped
        change_reg(REG_COLOR_FORMAT, {junk[DIM_W-1:2], f});
        change_reg(REG_TILE_LAYOUT, {junk[DIM_W-1:1], l});
        change_reg(REG_IMAGE_WIDTH, w[DIM_W-1:0]);
        change_reg(REG_IMAGE_HEIGHT, h[DIM_W-1:0]);
    endtask

    task automatic random_frame(input int k);
        color_fmt_t f;
        layout_t    l;
        int         w;
        int         h;
        int         r;
        int         need;
        int         tw;
        int         pixels;
        int         head;
        int         body;
        int         total;
        int         mid;
        int         style;
        case (k % 4)
            0:       begin send_idle = 0;  sink_stall = 0;  end
            1:       begin send_idle = 70; sink_stall = 0;  end
            2:       begin send_idle = 0;  sink_stall = 70; end
            default: begin send_idle = 22; sink_stall = 22; end
        endcase
        l = ($urandom_range(3) == 0) ? LAYOUT_PALETTE : LAYOUT_DIRECT;
        r = $urandom_range(19);
        if (l == LAYOUT_PALETTE)
            f = (r < 10) ? FMT_ALPHA8 : (r < 14) ? FMT_RGB655 :
                (r < 17) ? FMT_ABGR4444 : FMT_RGBA8888;
        else
            f = color_fmt_t'(r % 4);
        r = $urandom_range(99);
        if (r < 10)
        begin
            w = ($urandom_range(2) == 0) ? MAX_DIM : $urandom_range(1023);
            h = ($urandom_range(2) == 0) ? MAX_DIM : $urandom_range(1023);
        end
        else if (r < 40)
        begin
            w = 8 << $urandom_range(2);
            h = 8 << $urandom_range(1);
        end
        else
        begin
            w = $urandom_range(32);
            h = $urandom_range(16);
        end
        style = $urandom_range(99);
        // opening frames: a full direct image under sink pressure, then a palette image
        if (k == 0)
        begin
            f = FMT_ALPHA8; l = LAYOUT_DIRECT; w = 16; h = 16; style = 50;
        end
        else if (k == 1)
        begin
            f = FMT_ALPHA8; l = LAYOUT_PALETTE; w = 16; h = 8; style = 50;
        end
        setup_image(f, l, w, h);
        if (k % 7 == 0)
            hold_sink = 1'b1;

        need   = (f == FMT_ALPHA8) ? 1 : ((f == FMT_RGBA8888) ? 4 : 2);
        tw     = (l == LAYOUT_PALETTE) ? 16 : 8;
        w      = (w > MAX_DIM) ? MAX_DIM : w;
        h      = (h > MAX_DIM) ? MAX_DIM : h;
        pixels = (w / tw) * tw * (h / 8) * 8;
        head   = (l == LAYOUT_PALETTE) ? TABLE_ENTRIES * need : 0;
        body   = (l == LAYOUT_PALETTE) ? pixels : pixels * need;

        if (style < 10)
        begin
            repeat ($urandom_range(20, 60))
                send_byte(8'($urandom), $urandom_range(9) == 0);
            return;
        end
        if (pixels > 256 || style < 25)
            total = head + $urandom_range(1, 120);
        else
            total = head + body + $urandom_range(0, 6);
        mid = -1;
        if (style >= 90 && total > head)
            mid = head + $urandom_range(total - head - 1);
        for (int i = 0; i < total; i++)
        begin
            if (i == mid)
            begin
                case ($urandom_range(2))
                    0:       change_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(32)));
                    1:       change_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(16)));
                    default: change_reg(REG_COLOR_FORMAT, DIM_W'($urandom_range(3)));
                endcase
            end
            send_byte(8'($urandom), i == 0);
        end
    endtask

    initial
    begin
        int start;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_COLOR_FORMAT;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // oversized dimensions saturate
        setup_image(FMT_ALPHA8, LAYOUT_DIRECT, 1023, 1023);
        send_byte(8'h00, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
        // no whole tile: colours consumed, nothing emitted
        setup_image(FMT_RGB655, LAYOUT_DIRECT, 7, 0);
        send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        setup_image(FMT_RGB655, LAYOUT_DIRECT, 16, 8);
        send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'h3F, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'hC0, 1'b0); send_byte(8'h07, 1'b0);
        setup_image(FMT_ABGR4444, LAYOUT_DIRECT, 16, 8);
        send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0);
        send_byte(8'h21, 1'b0); send_byte(8'h43, 1'b0);
        setup_image(FMT_RGBA8888, LAYOUT_DIRECT, 16, 8);
        send_byte(8'h01, 1'b1); send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0); send_byte(8'hFF, 1'b0);
        // format drops to two bytes with two bytes of a colour already gathered
        send_byte(8'h8C, 1'b0); send_byte(8'h80, 1'b0);
        change_reg(REG_COLOR_FORMAT, DIM_W'(FMT_RGB655));
        send_byte(8'h7F, 1'b0);
        // narrower image while the tile is half done
        change_reg(REG_IMAGE_WIDTH, DIM_W'(8));
        send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);

        start = bytes_sent;
        for (int k = 0; bytes_sent - start < RANDOM_BYTES; k++)
            random_frame(k);

        send_idle  = 0;
        sink_stall = 0;
        drain();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
